// ===== rtl/core/manchester_frame_transmitter_assert.svh =====
// Assertion macros for the frame transmitter.
// Both macros take a label, clock, reset, antecedent and consequent.
`ifndef MANCHESTER_FRAME_TRANSMITTER_ASSERT_SVH
`define MANCHESTER_FRAME_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS

`define MFT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MFT_ASSERT_SAME(label, clk, rst, ante, cons)

`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/mft_pkg.sv =====
`timescale 1ns / 1ps

package mft_pkg;

   localparam int unsigned FRAME_LEN  = 5;
   localparam int unsigned FRAME_BITS = FRAME_LEN * 8;

   localparam logic [7:0] SYNC_HI = 8'hA5;
   localparam logic [7:0] SYNC_LO = 8'h5A;

   localparam int unsigned TICK_W = 10;
   localparam int unsigned ADDR_W = 5;

   localparam logic [TICK_W-1:0] RST_PREAMBLE_HALF = 10'd150;
   localparam logic [TICK_W-1:0] RST_START_HIGH    = 10'd500;
   localparam logic [TICK_W-1:0] RST_START_LOW     = 10'd125;
   localparam logic [TICK_W-1:0] RST_BIT_HALF      = 10'd125;

   localparam logic [2:0] LAST_BIT  = 3'd7;
   localparam logic [2:0] LAST_BYTE = 3'(FRAME_LEN - 1);

   typedef enum logic [2:0] {
      REG_NODE_ID       = 3'd0,
      REG_PREAMBLE_HALF = 3'd1,
      REG_START_HIGH    = 3'd2,
      REG_START_LOW     = 3'd3,
      REG_BIT_HALF      = 3'd4
   } csr_reg_type;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'b00001,
      PH_PREAMBLE   = 5'b00010,
      PH_START_HIGH = 5'b00100,
      PH_START_LOW  = 5'b01000,
      PH_DATA       = 5'b10000
   } phase_type;

   // command codes on the request channel
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

endpackage

// ===== rtl/core/manchester_frame_transmitter.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake                | payload
// req     | in        | req_valid / req_ready    | command, message_code
// rsp     | out       | rsp_valid / rsp_ready    | line_level, busy_res, frame_done,
//         |           |                          | request_ignored
// csr     | in/out    | APB psel/penable/pready  | node id and four tick counts
//
// One item per cycle: each tick or send request goes through the phase/count
// update and lands in the result register in the cycle after its transfer.
// The only limit on rate is the single result register; req_ready drops only
// while a result is held by rsp_ready low. Reset is synchronous and clears
// phase, counters, line level, rsp_valid and the config registers to their defaults.

`include "manchester_frame_transmitter_assert.svh"

module manchester_frame_transmitter #(
   parameter int unsigned PREAMBLE_HALVES = 8
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_command,
   input  logic [7:0]                 req_message_code,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_line_level,
   output logic                       rsp_busy_res,
   output logic                       rsp_frame_done,
   output logic                       rsp_request_ignored,

   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mft_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   import mft_pkg::*;

   localparam int unsigned HALF_W = $clog2(PREAMBLE_HALVES);
   localparam logic [HALF_W:0] PRE_END = (HALF_W + 1)'(PREAMBLE_HALVES);

   // configuration registers
   logic [7:0]        node_id_ff;
   logic [TICK_W-1:0] pre_half_ff;
   logic [TICK_W-1:0] start_high_ff;
   logic [TICK_W-1:0] start_low_ff;
   logic [TICK_W-1:0] bit_half_ff;

   // frame state
   phase_type            phase_ff,  phase_in;
   logic [TICK_W-1:0]    tick_ff,   tick_in;
   logic [HALF_W-1:0]    half_ff,   half_in;
   logic [2:0]           byte_ff,   byte_in;
   logic [2:0]           bit_ff,    bit_in;
   logic                 line_ff,   line_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;

   // result register
   logic rsp_valid_ff;
   logic line_out_ff, busy_out_ff, done_out_ff, ignored_out_ff;

   logic                  req_take;
   logic                  csr_write;
   logic                  done_in, ignored_in;
   logic [TICK_W-1:0]     tick_inc;
   logic [TICK_W-1:0]     seg_raw, seg_len;
   logic [HALF_W:0]       half_inc;
   logic [FRAME_BITS-1:0] frame_shift;
   logic [7:0]            check_sum;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff    <= '0;
         pre_half_ff   <= RST_PREAMBLE_HALF;
         start_high_ff <= RST_START_HIGH;
         start_low_ff  <= RST_START_LOW;
         bit_half_ff   <= RST_BIT_HALF;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_paddr[ADDR_W-1:2]))
            REG_NODE_ID:       node_id_ff    <= csr_pwdata[7:0];
            REG_PREAMBLE_HALF: pre_half_ff   <= csr_pwdata[TICK_W-1:0];
            REG_START_HIGH:    start_high_ff <= csr_pwdata[TICK_W-1:0];
            REG_START_LOW:     start_low_ff  <= csr_pwdata[TICK_W-1:0];
            REG_BIT_HALF:      bit_half_ff   <= csr_pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[ADDR_W-1:2]))
         REG_NODE_ID:       csr_prdata = {24'd0, node_id_ff};
         REG_PREAMBLE_HALF: csr_prdata = {22'd0, pre_half_ff};
         REG_START_HIGH:    csr_prdata = {22'd0, start_high_ff};
         REG_START_LOW:     csr_prdata = {22'd0, start_low_ff};
         REG_BIT_HALF:      csr_prdata = {22'd0, bit_half_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      case (phase_ff)
         PH_PREAMBLE:   seg_raw = pre_half_ff;
         PH_START_HIGH: seg_raw = start_high_ff;
         PH_START_LOW:  seg_raw = start_low_ff;
         default:       seg_raw = bit_half_ff;
      endcase
   end

   // a zero duration still lasts one tick
   assign seg_len     = (seg_raw == '0) ? TICK_W'(1) : seg_raw;
   assign tick_inc    = tick_ff + TICK_W'(1);
   assign half_inc    = {1'b0, half_ff} + (HALF_W + 1)'(1);
   assign frame_shift = {frame_ff[FRAME_BITS-2:0], 1'b0};
   assign check_sum   = SYNC_HI + SYNC_LO + node_id_ff + req_message_code;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      half_in    = half_ff;
      byte_in    = byte_ff;
      bit_in     = bit_ff;
      line_in    = line_ff;
      frame_in   = frame_ff;
      done_in    = 1'b0;
      ignored_in = 1'b0;

      if (req_command == CMD_SEND) begin
         if (phase_ff != PH_IDLE) begin
            ignored_in = 1'b1;
         end else begin
            frame_in = {SYNC_HI, SYNC_LO, node_id_ff, req_message_code, ~check_sum};
            phase_in = PH_PREAMBLE;
            tick_in  = '0;
            half_in  = '0;
            byte_in  = '0;
            bit_in   = '0;
            line_in  = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         tick_in = tick_inc;
         if (tick_inc == '0 || tick_inc >= seg_len) begin
            tick_in = '0;
            case (phase_ff)
               PH_PREAMBLE: begin
                  if (half_inc >= PRE_END) begin
                     half_in  = '0;
                     phase_in = PH_START_HIGH;
                     line_in  = 1'b1;
                  end else begin
                     half_in = half_inc[HALF_W-1:0];
                     line_in = !half_inc[0];
                  end
               end
               PH_START_HIGH: begin
                  phase_in = PH_START_LOW;
                  line_in  = 1'b0;
               end
               PH_START_LOW: begin
                  phase_in = PH_DATA;
                  byte_in  = '0;
                  bit_in   = '0;
                  half_in  = '0;
                  line_in  = !frame_ff[FRAME_BITS-1];
               end
               PH_DATA: begin
                  if (half_ff == '0) begin
                     half_in = HALF_W'(1);
                     line_in = frame_ff[FRAME_BITS-1];
                  end else begin
                     half_in  = '0;
                     frame_in = frame_shift;
                     line_in  = !frame_shift[FRAME_BITS-1];
                     if (bit_ff == LAST_BIT) begin
                        bit_in = '0;
                        if (byte_ff == LAST_BYTE) begin
                           byte_in  = '0;
                           phase_in = PH_IDLE;
                           line_in  = 1'b0;
                           done_in  = 1'b1;
                        end else begin
                           byte_in = byte_ff + 3'd1;
                        end
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         half_ff  <= '0;
         byte_ff  <= '0;
         bit_ff   <= '0;
         line_ff  <= 1'b0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         half_ff  <= half_in;
         byte_ff  <= byte_in;
         bit_ff   <= bit_in;
         line_ff  <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         line_out_ff    <= line_in;
         busy_out_ff    <= (phase_in != PH_IDLE);
         done_out_ff    <= done_in;
         ignored_out_ff <= ignored_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_line_level      = line_out_ff;
   assign rsp_busy_res        = busy_out_ff;
   assign rsp_frame_done      = done_out_ff;
   assign rsp_request_ignored = ignored_out_ff;

   // a held result blocks the next transfer
   `MFT_ASSERT_SAME(a_hold_blocks, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   // line is always low while idle
   `MFT_ASSERT_SAME(a_idle_low, clock, reset, phase_ff == PH_IDLE, !line_ff)
   // a finished frame reports not busy and line low
   `MFT_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid_ff && rsp_frame_done,
                    !rsp_busy_res && !rsp_line_level)
   // a send while busy comes back flagged as ignored
   `MFT_ASSERT_NEXT(a_ignored, clock, reset,
                    req_take && req_command == CMD_SEND && phase_ff != PH_IDLE,
                    rsp_valid_ff && rsp_request_ignored)

endmodule
